FILE: design/pidpi_pkg.sv
// ============================================================================
// PID regulator package
// Shared types, register indexes and fixed-point helpers for the positional
// and incremental PID regulator.
// ============================================================================
package pidpi_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int LIMIT_W   = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [63:0] RND_BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;
    localparam logic signed [63:0] I32_MAX  = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN  = -64'sd2147483648;

    typedef enum logic
    {
        LOOP_POSITIONAL  = 1'b0,
        LOOP_INCREMENTAL = 1'b1
    } loop_mode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_LOOP_MODE   = 3'd0,
        CFG_SETPOINT    = 3'd1,
        CFG_GAIN_P      = 3'd2,
        CFG_GAIN_I      = 3'd3,
        CFG_GAIN_D      = 3'd4,
        CFG_OUT_LIMIT   = 3'd5,
        CFG_INTEG_LIMIT = 3'd6
    } cfg_index_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > I32_MAX)
        begin
            r = I32_MAX[DATA_W-1:0];
        end
        else if (v < I32_MIN)
        begin
            r = I32_MIN[DATA_W-1:0];
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Full product, shifted down with rounding toward zero, then saturated.
    function automatic logic signed [DATA_W-1:0] fx_mul(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [63:0] prod;
        logic signed [63:0] adj;
        prod = 64'(a) * 64'(b);
        adj  = prod + (prod[63] ? RND_BIAS : 64'sd0);
        return sat32(adj >>> FRAC_BITS);
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_sym(
        input logic signed [DATA_W-1:0] v,
        input logic [LIMIT_W-1:0]       lim
    );
        logic signed [DATA_W:0] v_ext;
        logic signed [DATA_W:0] lim_pos;
        logic signed [DATA_W:0] lim_neg;
        logic signed [DATA_W:0] r;
        v_ext   = (DATA_W+1)'(v);
        lim_pos = $signed({2'b00, lim});
        lim_neg = -lim_pos;
        if (v_ext > lim_pos)
        begin
            r = lim_pos;
        end
        else if (v_ext < lim_neg)
        begin
            r = lim_neg;
        end
        else
        begin
            r = v_ext;
        end
        return r[DATA_W-1:0];
    endfunction

endpackage

FILE: design/pidpi_if.sv
// ============================================================================
// PID regulator channels
// Valid/ready channels for measured samples and drive results.
// ============================================================================
interface pidpi_meas_if;
    import pidpi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] measured;

    modport source (output valid, output measured, input ready);
    modport sink (input valid, input measured, output ready);
endinterface

interface pidpi_drive_if;
    import pidpi_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink (input valid, input drive, output ready);
endinterface

FILE: design/pid_positional_incremental_top.sv
// ============================================================================
// PID regulator, positional and incremental
// Computes one clamped drive value per measured sample from the error, its
// two predecessors, an integrator and the previous drive, in signed Q16.16.
// ============================================================================
//
//  Channel   Direction  Transaction payload
//  meas      in         measured  (32-bit signed)
//  result    out        drive     (32-bit signed)
//  cfg       in         cfg_index (3 bits), cfg_data (32 bits), cfg_we
//
// One transaction is accepted per cycle while the result channel does not
// stall. The first stage registers the error, the second runs the three
// multipliers, the sums and the clamps into the drive register. A stalled
// result holds both stages while the input register still takes a sample
// if it is empty. Reset loads the default gains and limits and clears the
// error history, the integrator and the drive.
module pid_positional_incremental_top
    import pidpi_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    pidpi_meas_if.sink           meas,
    pidpi_drive_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    loop_mode_t                loop_mode_reg;
    logic signed [DATA_W-1:0]  setpoint_reg;
    logic signed [DATA_W-1:0]  gain_p_reg;
    logic signed [DATA_W-1:0]  gain_i_reg;
    logic signed [DATA_W-1:0]  gain_d_reg;
    logic [LIMIT_W-1:0]        out_limit_reg;
    logic [LIMIT_W-1:0]        integ_limit_reg;

    logic                      valid_a_reg;
    logic signed [DATA_W-1:0]  err_a_reg;
    logic                      out_valid_reg;

    logic signed [DATA_W-1:0]  err_h0_reg;
    logic signed [DATA_W-1:0]  err_h1_reg;
    logic signed [DATA_W-1:0]  integ_reg;
    logic signed [DATA_W-1:0]  acc_reg;

    logic signed [DATA_W-1:0]  err_in;
    logic                      advance;
    logic                      fire_b;
    logic                      incremental;
    logic signed [DATA_W-1:0]  diff1;
    logic signed [DATA_W-1:0]  diff2;
    logic signed [DATA_W-1:0]  p_op;
    logic signed [DATA_W-1:0]  d_op;
    logic signed [DATA_W-1:0]  p_term;
    logic signed [DATA_W-1:0]  i_term;
    logic signed [DATA_W-1:0]  d_term;
    logic signed [DATA_W-1:0]  integ_pos;
    logic signed [63:0]        base;
    logic signed [DATA_W-1:0]  sum;
    logic signed [DATA_W-1:0]  integ_next;
    logic signed [DATA_W-1:0]  acc_next;

    assign advance      = !out_valid_reg || result.ready;
    assign meas.ready   = !valid_a_reg || advance;
    assign fire_b       = valid_a_reg && advance;
    assign result.valid = out_valid_reg;
    assign result.drive = acc_reg;

    assign err_in = sat32(64'(setpoint_reg) - 64'(meas.measured));

    always_comb
    begin
        incremental = (loop_mode_reg == LOOP_INCREMENTAL);
        diff1 = sat32(64'(err_a_reg) - 64'(err_h0_reg));
        diff2 = sat32(64'(err_a_reg) - 64'(err_h0_reg) - 64'(err_h0_reg) + 64'(err_h1_reg));
        p_op  = incremental ? diff1 : err_a_reg;
        d_op  = incremental ? diff2 : diff1;

        p_term = fx_mul(gain_p_reg, p_op);
        i_term = fx_mul(gain_i_reg, err_a_reg);
        d_term = fx_mul(gain_d_reg, d_op);

        integ_pos  = clamp_sym(sat32(64'(integ_reg) + 64'(i_term)), integ_limit_reg);
        integ_next = incremental ? i_term : integ_pos;
        base       = incremental ? (64'(acc_reg) + 64'(i_term)) : 64'(integ_pos);
        sum        = sat32(base + 64'(p_term) + 64'(d_term));
        acc_next   = clamp_sym(sum, out_limit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loop_mode_reg   <= LOOP_POSITIONAL;
            setpoint_reg    <= 32'sd1966080;
            gain_p_reg      <= 32'sd32768;
            gain_i_reg      <= 32'sd655;
            gain_d_reg      <= 32'sd0;
            out_limit_reg   <= 31'd655360;
            integ_limit_reg <= 31'd327680;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_LOOP_MODE:   loop_mode_reg   <= loop_mode_t'(cfg_data[0]);
                CFG_SETPOINT:    setpoint_reg    <= $signed(cfg_data);
                CFG_GAIN_P:      gain_p_reg      <= $signed(cfg_data);
                CFG_GAIN_I:      gain_i_reg      <= $signed(cfg_data);
                CFG_GAIN_D:      gain_d_reg      <= $signed(cfg_data);
                CFG_OUT_LIMIT:   out_limit_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_INTEG_LIMIT: integ_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            err_h0_reg    <= '0;
            err_h1_reg    <= '0;
            integ_reg     <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            if (meas.ready)
            begin
                valid_a_reg <= meas.valid;
            end
            if (advance)
            begin
                out_valid_reg <= valid_a_reg;
            end
            if (fire_b)
            begin
                err_h0_reg <= err_a_reg;
                err_h1_reg <= err_h0_reg;
                integ_reg  <= integ_next;
                acc_reg    <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas.valid && meas.ready)
        begin
            err_a_reg <= err_in;
        end
    end

    // The drive shown never exceeds the output limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((DATA_W+1)'(result.drive) <= $signed({2'b00, out_limit_reg}))
            && ((DATA_W+1)'(result.drive) >= -$signed({2'b00, out_limit_reg})))
        else $error("drive outside the output limit");

    // A positional update leaves the integrator inside its limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire_b && loop_mode_reg == LOOP_POSITIONAL) |=>
            ((DATA_W+1)'(integ_reg) <= $signed({2'b00, integ_limit_reg}))
            && ((DATA_W+1)'(integ_reg) >= -$signed({2'b00, integ_limit_reg})))
        else $error("integrator outside its limit after a positional update");

    // The error history shifts by exactly one entry per processed transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire_b |=> (err_h0_reg == $past(err_a_reg)) && (err_h1_reg == $past(err_h0_reg)))
        else $error("error history did not shift correctly");

    // A stalled first stage keeps its error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_a_reg && !advance) |=> valid_a_reg && $stable(err_a_reg))
        else $error("first stage lost its transaction during a stall");

    // Drive and state change only when a transaction is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire_b |=> $stable(acc_reg) && $stable(integ_reg))
        else $error("state changed without a transaction");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// PID regulator testbench
// Drives measured samples through the valid/ready channel and writes the
// gains, limits, setpoint and loop mode between phases. A built-in fixed-point
// model of the positional and incremental regulator predicts each drive value,
// and every drive transaction is compared against the oldest prediction.
// Directed tests cover the field extremes, both loop modes, mode switching and
// register masking; random phases follow with random stalls on both sides.
// ============================================================================
module tb_top;
    import pidpi_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int PIPE_DEPTH  = 2;
    localparam int RAND_PHASES = 12;
    localparam int CYCLE_LIMIT = 500000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0]    cfg_data;
    logic                 sink_ready = 1'b0;
    logic                 idle_on = 1'b1;
    int                   stall_left = 0;
    int                   cycle_count = 0;
    int                   fail_count = 0;

    logic signed [DATA_W-1:0] expected_drives[$];
    logic signed [DATA_W-1:0] wanted_drive;

    loop_mode_t               mode_q;
    logic signed [DATA_W-1:0] setpoint_q;
    logic signed [DATA_W-1:0] gain_p_q;
    logic signed [DATA_W-1:0] gain_i_q;
    logic signed [DATA_W-1:0] gain_d_q;
    logic [LIMIT_W-1:0]       out_limit_q;
    logic [LIMIT_W-1:0]       integ_limit_q;
    logic signed [DATA_W-1:0] err1_q;
    logic signed [DATA_W-1:0] err2_q;
    logic signed [DATA_W-1:0] integ_q;
    logic signed [DATA_W-1:0] drive_q;

    pidpi_meas_if  meas_ch();
    pidpi_drive_if drive_ch();

    assign drive_ch.ready = sink_ready;

    pid_positional_incremental_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .meas      (meas_ch),
        .result    (drive_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            sink_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            sink_ready <= 1'b0;
            stall_left <= $urandom_range(0, 17);
        end
        else
        begin
            sink_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && drive_ch.valid && drive_ch.ready)
        begin
            if (expected_drives.size() == 0)
            begin
                $display("%0t: unexpected drive transaction, actual %0d", $time,
                         drive_ch.drive);
                fail_count++;
            end
            else
            begin
                wanted_drive = expected_drives.pop_front();
                if (drive_ch.drive !== wanted_drive)
                begin
                    $display("%0t: drive mismatch, expected %0d actual %0d", $time,
                             wanted_drive, drive_ch.drive);
                    fail_count++;
                end
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] sat_word(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            return 32'sh7FFF_FFFF;
        end
        if (v < longint'(32'sh8000_0000))
        begin
            return 32'sh8000_0000;
        end
        return DATA_W'(v);
    endfunction

    function automatic logic signed [DATA_W-1:0] q_mul(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        longint prod;
        longint mag;
        prod = longint'(a) * longint'(b);
        mag  = (prod < 0) ? -prod : prod;
        mag  = mag >> FRAC_BITS;
        return sat_word((prod < 0) ? -mag : mag);
    endfunction

    function automatic logic signed [DATA_W-1:0] limit_sym(input logic signed [DATA_W-1:0] v,
                                                           input logic [LIMIT_W-1:0] lim);
        longint l;
        longint x;
        l = longint'(lim);
        x = longint'(v);
        if (x > l)
        begin
            return DATA_W'(l);
        end
        if (x < -l)
        begin
            return DATA_W'(-l);
        end
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] predict_drive(
        input logic signed [DATA_W-1:0] m
    );
        logic signed [DATA_W-1:0] e;
        logic signed [DATA_W-1:0] pt;
        logic signed [DATA_W-1:0] it;
        logic signed [DATA_W-1:0] dt;
        logic signed [DATA_W-1:0] s;
        e = sat_word(longint'(setpoint_q) - longint'(m));
        if (mode_q == LOOP_POSITIONAL)
        begin
            pt      = q_mul(gain_p_q, e);
            integ_q = sat_word(longint'(integ_q) + longint'(q_mul(gain_i_q, e)));
            dt      = q_mul(gain_d_q, sat_word(longint'(e) - longint'(err1_q)));
            integ_q = limit_sym(integ_q, integ_limit_q);
            s       = sat_word(longint'(pt) + longint'(integ_q) + longint'(dt));
        end
        else
        begin
            pt      = q_mul(gain_p_q, sat_word(longint'(e) - longint'(err1_q)));
            it      = q_mul(gain_i_q, e);
            integ_q = it;
            dt      = q_mul(gain_d_q, sat_word(longint'(e) - 2 * longint'(err1_q)
                                               + longint'(err2_q)));
            s       = sat_word(longint'(drive_q) + longint'(pt) + longint'(it)
                               + longint'(dt));
        end
        drive_q = limit_sym(s, out_limit_q);
        err2_q  = err1_q;
        err1_q  = e;
        return drive_q;
    endfunction

    task automatic reset_model();
        mode_q        = LOOP_POSITIONAL;
        setpoint_q    = 32'sd1966080;
        gain_p_q      = 32'sd32768;
        gain_i_q      = 32'sd655;
        gain_d_q      = '0;
        out_limit_q   = 31'd655360;
        integ_limit_q = 31'd327680;
        err1_q        = '0;
        err2_q        = '0;
        integ_q       = '0;
        drive_q       = '0;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_LOOP_MODE:   mode_q        = loop_mode_t'(val[0]);
            CFG_SETPOINT:    setpoint_q    = val;
            CFG_GAIN_P:      gain_p_q      = val;
            CFG_GAIN_I:      gain_i_q      = val;
            CFG_GAIN_D:      gain_d_q      = val;
            CFG_OUT_LIMIT:   out_limit_q   = val[LIMIT_W-1:0];
            CFG_INTEG_LIMIT: integ_limit_q = val[LIMIT_W-1:0];
            default:         ;
        endcase
    endtask

    task automatic send_sample(input logic signed [DATA_W-1:0] m);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 18);
        end
        if (gap > 0)
        begin
            meas_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        meas_ch.valid    <= 1'b1;
        meas_ch.measured <= m;
        @(posedge clk);
        while (!meas_ch.ready)
        begin
            @(posedge clk);
        end
        expected_drives.push_back(predict_drive(m));
    endtask

    task automatic drain();
        meas_ch.valid <= 1'b0;
        while (expected_drives.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic configure(input logic [DATA_W-1:0] mode_w, input logic [DATA_W-1:0] sp,
                             input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] ki,
                             input logic [DATA_W-1:0] kd, input logic [DATA_W-1:0] olim,
                             input logic [DATA_W-1:0] ilim);
        drain();
        write_reg(CFG_LOOP_MODE, mode_w);
        write_reg(CFG_SETPOINT, sp);
        write_reg(CFG_GAIN_P, kp);
        write_reg(CFG_GAIN_I, ki);
        write_reg(CFG_GAIN_D, kd);
        write_reg(CFG_OUT_LIMIT, olim);
        write_reg(CFG_INTEG_LIMIT, ilim);
    endtask

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return '0;
            default: return DATA_W'($urandom_range(0, 1 << 19)) - DATA_W'(1 << 17);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom;
            default: return DATA_W'($urandom_range(0, 1 << 24));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_setpoint();
        if ($urandom_range(0, 3) == 0)
        begin
            return $urandom;
        end
        return DATA_W'($urandom_range(0, 1 << 24)) - DATA_W'(1 << 23);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_sample();
        int span;
        span = 1 << $urandom_range(2, 22);
        case ($urandom_range(0, 15))
            0:       return $urandom;
            1:       return 32'sh7FFF_FFFF;
            2:       return 32'sh8000_0000;
            default: return setpoint_q + DATA_W'($urandom_range(0, 2 * span)) - DATA_W'(span);
        endcase
    endfunction

    task automatic test_reset_defaults();
        send_sample('0);
        send_sample(32'sd1966080);
        send_sample(32'sh7FFF_FFFF);
        send_sample(32'sh8000_0000);
    endtask

    task automatic test_gain_extremes();
        configure(LOOP_POSITIONAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_sample(32'sh7FFF_FFFF);
        send_sample('0);
        send_sample(-32'sd1);
        send_sample(32'sd1);
        send_sample(32'sh8000_0000);
    endtask

    task automatic test_incremental();
        configure(LOOP_INCREMENTAL, '0, 32'h0001_0000, 32'h0000_4000, 32'h0000_8000,
                  32'h0064_0000, '0);
        send_sample(-32'sd65536);
        send_sample(-32'sd131072);
        send_sample(32'sd327680);
        send_sample(32'sh7FFF_FFFF);
        send_sample('0);
    endtask

    task automatic test_mode_switch();
        drain();
        write_reg(CFG_LOOP_MODE, LOOP_POSITIONAL);
        send_sample(32'sd98304);
        send_sample(-32'sd40000);
        drain();
        write_reg(CFG_LOOP_MODE, LOOP_INCREMENTAL);
        send_sample(32'sd12345);
        send_sample(-32'sd700000);
    endtask

    task automatic test_register_masking();
        configure(32'hFFFF_FFFE, '0, 32'h0001_8000, 32'hFFFF_FFFD, '0, 32'h80C8_0000, '0);
        write_reg(CFG_SPARE_INDEX, $urandom);
        send_sample(32'sd1);
        send_sample(32'sd3);
        send_sample(-32'sd65536);
    endtask

    task automatic test_random_phases();
        int n_items;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph >= RAND_PHASES - 2)
            begin
                idle_on <= 1'b0;
            end
            configure($urandom, pick_setpoint(), pick_gain(), pick_gain(), pick_gain(),
                      pick_limit(), pick_limit());
            n_items = $urandom_range(140, 185);
            repeat (n_items) send_sample(pick_sample());
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        meas_ch.valid    <= 1'b0;
        meas_ch.measured <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_gain_extremes();
        test_incremental();
        test_mode_switch();
        test_register_masking();
        test_random_phases();

        drain();
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: pid_positional_incremental_top.f
design/pidpi_pkg.sv
design/pidpi_if.sv
design/pid_positional_incremental_top.sv
dv/tb_top.sv
